/* sv/rkss_pkg.sv */
package rkss_pkg;

    // store geometry
    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic signed [DATA_W-1:0] data_t;

    // operation codes on func
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_GET    = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_RANK = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_FIN  = 4'b0100,
        S_GET  = 4'b1000
    } state_t;

    // memory access request: write port and read port
    typedef struct packed {
        logic  we;
        addr_t waddr;
        data_t wdata;
        logic  re;
        addr_t raddr;
    } ram_req_t;

endpackage

/* sv/running_kth_smallest_store_core.sv */
// Sorted multiset of signed 32-bit values with a running rank query.
// Input channel (in_valid / in_stall, func, new_value): func 0 inserts
// new_value, func 1 asks for the value at the next rank, smallest first.
// Output channel (out_valid / out_stall, result_value, status): one result
// per get, and one per insert into a full store; an insert that fits gives
// none. status 0 ok, 1 rank beyond stored count, 2 store full.
// Values sit in ascending order in a 1024-entry memory with a registered
// read. An insert walks down from the top, moving one larger entry up per
// cycle: into an empty store the value is written at once; else the top
// entry is read, each larger entry read is moved up one place, and the
// value is dropped in above the first entry not greater, or at the bottom.
// A successful get reads the memory, then loads the output register;
// error results are loaded straight into the output register.
// Reset empties the store and clears the rank; no clearing pass is needed.
// A stalled result sits in the output register; a new transfer is taken
// only while the sequencer is idle and the output register can be loaded.
module running_kth_smallest_store_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] new_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result_value,
    output logic [1:0]  status
);

    rkss_pkg::state_t   state_reg, state_next;
    rkss_pkg::cnt_t     count_reg, count_next;
    rkss_pkg::cnt_t     rank_reg, rank_next;
    rkss_pkg::addr_t    idx_reg, idx_next;
    rkss_pkg::data_t    val_reg, val_next;
    logic               out_valid_reg, out_valid_next;
    rkss_pkg::data_t    result_reg, result_next;
    logic [1:0]         status_reg, status_next;
    rkss_pkg::ram_req_t req;
    rkss_pkg::data_t    rd_data;
    logic               in_xfer;
    logic               out_xfer;
    logic               less;

    rkss_ram u_ram (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    // handshake
    assign in_stall = (state_reg != rkss_pkg::S_IDLE) || (out_valid_reg && out_stall);
    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid_reg && !out_stall;
    assign less     = $signed(val_reg) < rd_data;

    // sequencer and memory control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rank_next      = rank_reg;
        idx_next       = idx_reg;
        val_next       = val_reg;
        out_valid_next = out_xfer ? 1'b0 : out_valid_reg;
        result_next    = result_reg;
        status_next    = status_reg;
        req            = '0;

        case (state_reg)
            rkss_pkg::S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (func == rkss_pkg::FUNC_INSERT)
                    begin
                        if (count_reg >= rkss_pkg::CNT_W'(rkss_pkg::CAPACITY))
                        begin
                            out_valid_next = 1'b1;
                            result_next    = '0;
                            status_next    = rkss_pkg::ST_FULL;
                        end
                        else if (count_reg == '0)
                        begin
                            req.we     = 1'b1;
                            req.waddr  = '0;
                            req.wdata  = $signed(new_value);
                            count_next = rkss_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            req.re     = 1'b1;
                            req.raddr  = rkss_pkg::ADDR_W'(count_reg - rkss_pkg::CNT_W'(1));
                            idx_next   = rkss_pkg::ADDR_W'(count_reg - rkss_pkg::CNT_W'(1));
                            val_next   = $signed(new_value);
                            count_next = count_reg + rkss_pkg::CNT_W'(1);
                            state_next = rkss_pkg::S_INS;
                        end
                    end
                    else
                    begin
                        if (rank_reg >= count_reg)
                        begin
                            out_valid_next = 1'b1;
                            result_next    = '0;
                            status_next    = rkss_pkg::ST_RANK;
                        end
                        else
                        begin
                            req.re     = 1'b1;
                            req.raddr  = rkss_pkg::ADDR_W'(rank_reg);
                            rank_next  = rank_reg + rkss_pkg::CNT_W'(1);
                            state_next = rkss_pkg::S_GET;
                        end
                    end
                end
            end
            // compare with the entry just read, move it up or drop the value in
            rkss_pkg::S_INS:
            begin
                req.we    = 1'b1;
                req.waddr = idx_reg + rkss_pkg::ADDR_W'(1);
                if (less)
                begin
                    req.wdata = rd_data;
                    if (idx_reg == '0)
                    begin
                        state_next = rkss_pkg::S_FIN;
                    end
                    else
                    begin
                        req.re    = 1'b1;
                        req.raddr = idx_reg - rkss_pkg::ADDR_W'(1);
                        idx_next  = idx_reg - rkss_pkg::ADDR_W'(1);
                    end
                end
                else
                begin
                    req.wdata  = val_reg;
                    state_next = rkss_pkg::S_IDLE;
                end
            end
            // new value is the smallest so far
            rkss_pkg::S_FIN:
            begin
                req.we     = 1'b1;
                req.waddr  = '0;
                req.wdata  = val_reg;
                state_next = rkss_pkg::S_IDLE;
            end
            // read data is ready, load the output register
            rkss_pkg::S_GET:
            begin
                out_valid_next = 1'b1;
                result_next    = rd_data;
                status_next    = rkss_pkg::ST_OK;
                state_next     = rkss_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rkss_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rkss_pkg::S_IDLE;
            count_reg     <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rank_reg      <= rank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

    // checks
    a_ins_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rkss_pkg::S_INS) |->
        (rkss_pkg::CNT_W'(idx_reg) + rkss_pkg::CNT_W'(1) < count_reg))
        else $error("insert index beyond stored count");

    a_rank_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        rank_reg <= count_reg)
        else $error("query rank beyond stored count");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rkss_pkg::CNT_W'(rkss_pkg::CAPACITY))
        else $error("stored count beyond capacity");

    a_get_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rkss_pkg::S_GET) |=> (out_valid_reg && status_reg == rkss_pkg::ST_OK))
        else $error("get read did not load a result");

endmodule

/* sv/rkss_ram.sv */
module rkss_ram (
    input  logic               clk,
    input  rkss_pkg::ram_req_t req,
    output rkss_pkg::data_t    rd_data
);

    rkss_pkg::data_t mem [rkss_pkg::CAPACITY];
    rkss_pkg::data_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // registered read port, holds when not reading
    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
